### design/lzdc_pkg.sv
// ----------------------------------------------------------------------------
// lzdc_pkg
// Shared constants and types for the LZSS window decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzdc_pkg;

    localparam int WINDOW_BYTES_DEF = 2048;
    localparam int BYTE_W           = 8;
    localparam int CFG_W            = 11;
    localparam int LEN_W            = 6;

    localparam logic [CFG_W-1:0] CFG_RESET     = 11'd2015;
    localparam logic [3:0]       FLAGS_PER_CTL = 4'd8;
    localparam logic [LEN_W-1:0] MIN_MATCH     = 6'd2;

    typedef struct packed {
        logic start_stream;
        logic hold_low;
        logic lit_write;
        logic copy_start;
        logic rd_issue;
        logic consume;
        logic consume_last;
    } lzdc_cmd_t;

    typedef struct packed {
        logic out_free;
    } lzdc_stat_t;

endpackage

`default_nettype wire

### design/lzdc_ram.sv
// ----------------------------------------------------------------------------
// lzdc_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lzdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/lzdc_ctrl.sv
// ----------------------------------------------------------------------------
// lzdc_ctrl
// Controller: decodes control flags and pairs, sequences match copies.
// ----------------------------------------------------------------------------
`default_nettype none

module lzdc_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [lzdc_pkg::BYTE_W-1:0] byte_in,
    input  wire logic                       first_in,
    input  wire logic                       last_in,
    input  wire lzdc_pkg::lzdc_stat_t       stat,
    output lzdc_pkg::lzdc_cmd_t             cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } state_t;

    state_t                          state_reg, state_next;
    logic [lzdc_pkg::BYTE_W-1:0]     ctl_bits_reg, ctl_bits_next;
    logic [3:0]                      ctl_left_reg, ctl_left_next;
    logic                            awaiting_reg, awaiting_next;
    logic [lzdc_pkg::LEN_W-1:0]      rem_reg, rem_next;
    logic                            rd_pending_reg, rd_pending_next;

    logic                            accept;
    logic [lzdc_pkg::BYTE_W-1:0]     ctl_eff;
    logic [3:0]                      left_eff;
    logic                            await_eff;

    assign s_axis_tready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ctl_eff       = first_in ? '0 : ctl_bits_reg;
    assign left_eff      = first_in ? '0 : ctl_left_reg;
    assign await_eff     = first_in ? 1'b0 : awaiting_reg;

    always_comb
    begin
        state_next      = state_reg;
        ctl_bits_next   = ctl_bits_reg;
        ctl_left_next   = ctl_left_reg;
        awaiting_next   = awaiting_reg;
        rem_next        = rem_reg;
        rd_pending_next = rd_pending_reg;
        cmd             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.start_stream = first_in;
                    ctl_bits_next    = ctl_eff;
                    ctl_left_next    = left_eff;
                    awaiting_next    = await_eff;
                    if (left_eff == '0)
                    begin
                        ctl_bits_next = byte_in;
                        ctl_left_next = lzdc_pkg::FLAGS_PER_CTL;
                    end
                    else if (await_eff)
                    begin
                        cmd.copy_start  = 1'b1;
                        rem_next        = lzdc_pkg::LEN_W'(byte_in[4:0]) + lzdc_pkg::MIN_MATCH;
                        awaiting_next   = 1'b0;
                        ctl_bits_next   = ctl_eff >> 1;
                        ctl_left_next   = left_eff - 4'd1;
                        rd_pending_next = 1'b0;
                        state_next      = ST_COPY;
                    end
                    else if (ctl_eff[0])
                    begin
                        cmd.lit_write = 1'b1;
                        ctl_bits_next = ctl_eff >> 1;
                        ctl_left_next = left_eff - 4'd1;
                    end
                    else
                    begin
                        cmd.hold_low  = 1'b1;
                        awaiting_next = 1'b1;
                    end
                    if (last_in)
                    begin
                        awaiting_next = 1'b0;
                    end
                end
            end
            ST_COPY:
            begin
                cmd.consume      = rd_pending_reg && stat.out_free;
                cmd.consume_last = cmd.consume && (rem_reg == lzdc_pkg::LEN_W'(1));
                cmd.rd_issue     = (rem_reg > lzdc_pkg::LEN_W'(rd_pending_reg))
                                   && (!rd_pending_reg || cmd.consume);
                if (cmd.consume)
                begin
                    rem_next = rem_reg - lzdc_pkg::LEN_W'(1);
                    if (cmd.consume_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                if (cmd.rd_issue)
                begin
                    rd_pending_next = 1'b1;
                end
                else if (cmd.consume)
                begin
                    rd_pending_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ctl_bits_reg   <= '0;
            ctl_left_reg   <= '0;
            awaiting_reg   <= 1'b0;
            rem_reg        <= '0;
            rd_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ctl_bits_reg   <= ctl_bits_next;
            ctl_left_reg   <= ctl_left_next;
            awaiting_reg   <= awaiting_next;
            rem_reg        <= rem_next;
            rd_pending_reg <= rd_pending_next;
        end
    end

endmodule

`default_nettype wire

### design/lzdc_dpath.sv
// ----------------------------------------------------------------------------
// lzdc_dpath
// Datapath: history window, write pointer, fill count, copy address and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lzdc_dpath #(
    parameter int WINDOW_BYTES = lzdc_pkg::WINDOW_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [lzdc_pkg::CFG_W-1:0]  cfg_wr_data,
    input  wire logic [lzdc_pkg::BYTE_W-1:0] byte_in,
    input  wire lzdc_pkg::lzdc_cmd_t         cmd,
    output lzdc_pkg::lzdc_stat_t             stat,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [lzdc_pkg::BYTE_W-1:0]      m_axis_tdata,
    output logic                             m_axis_tlast
);

    localparam int ADDR_W = $clog2(WINDOW_BYTES);
    localparam int FILL_W = ADDR_W + 1;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_BYTES);

    logic [ADDR_W-1:0]           cfg_reg;
    logic [ADDR_W-1:0]           base_reg;
    logic [ADDR_W-1:0]           wp_reg;
    logic [FILL_W-1:0]           fill_reg;
    logic [ADDR_W-1:0]           rd_addr_reg;
    logic [lzdc_pkg::BYTE_W-1:0] held_reg;
    logic                        byp_reg;
    logic [lzdc_pkg::BYTE_W-1:0] byp_data_reg;
    logic                        rd_ok_reg;
    logic                        out_valid_reg;
    logic [lzdc_pkg::BYTE_W-1:0] out_data_reg;
    logic                        out_last_reg;

    logic [ADDR_W-1:0]           wp_use;
    logic [FILL_W-1:0]           fill_use;
    logic [FILL_W-1:0]           fill_inc;
    logic [ADDR_W-1:0]           rd_dist;
    logic                        rd_hit;
    logic                        byp_hit;
    logic                        wr_en;
    logic [lzdc_pkg::BYTE_W-1:0] wr_data;
    logic [lzdc_pkg::BYTE_W-1:0] ram_q;
    logic [lzdc_pkg::BYTE_W-1:0] cur_byte;

    assign wp_use   = cmd.start_stream ? cfg_reg : wp_reg;
    assign fill_use = cmd.start_stream ? '0 : fill_reg;
    assign fill_inc = (fill_use == FILL_FULL) ? fill_use : fill_use + FILL_W'(1);
    assign rd_dist  = rd_addr_reg - base_reg;
    assign rd_hit   = {1'b0, rd_dist} < fill_reg;
    assign byp_hit  = cmd.consume && (wp_reg == rd_addr_reg);
    assign cur_byte = byp_reg ? byp_data_reg : (rd_ok_reg ? ram_q : '0);
    assign wr_en    = cmd.lit_write || cmd.consume;
    assign wr_data  = cmd.lit_write ? byte_in : cur_byte;

    assign stat.out_free = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    lzdc_ram #(
        .WIDTH (lzdc_pkg::BYTE_W),
        .DEPTH (WINDOW_BYTES)
    ) u_window (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_use),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_issue),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= ADDR_W'(lzdc_pkg::CFG_RESET);
            base_reg      <= ADDR_W'(lzdc_pkg::CFG_RESET);
            wp_reg        <= ADDR_W'(lzdc_pkg::CFG_RESET);
            fill_reg      <= '0;
            byp_reg       <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data[ADDR_W-1:0];
            end
            if (cmd.start_stream)
            begin
                base_reg <= cfg_reg;
            end
            if (wr_en)
            begin
                wp_reg   <= wp_use + ADDR_W'(1);
                fill_reg <= fill_inc;
            end
            else if (cmd.start_stream)
            begin
                wp_reg   <= cfg_reg;
                fill_reg <= '0;
            end
            if (cmd.rd_issue)
            begin
                byp_reg   <= byp_hit;
                rd_ok_reg <= rd_hit;
            end
            if (wr_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.copy_start)
        begin
            rd_addr_reg <= ADDR_W'({byte_in[7:5], held_reg});
        end
        else if (cmd.rd_issue)
        begin
            rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
        end
        if (cmd.hold_low)
        begin
            held_reg <= byte_in;
        end
        if (cmd.rd_issue)
        begin
            byp_data_reg <= wr_data;
        end
        if (wr_en)
        begin
            out_data_reg <= wr_data;
            out_last_reg <= cmd.lit_write || cmd.consume_last;
        end
    end

endmodule

`default_nettype wire

### design/lzss_window_decompressor_core.sv
// ----------------------------------------------------------------------------
// lzss_window_decompressor_core
// LZSS decompressor with a 2048-byte history window.
// ----------------------------------------------------------------------------
// The input stream carries one compressed byte per item; tuser marks the
// first byte of a stream, which clears the window and the decoder state,
// and tlast marks the final byte, after which a half-read pair is dropped.
// The output stream carries one plain byte per item, with tlast set on the
// final byte produced by each input item.
// A literal appears at the output in the cycle after it is accepted. A match
// of N bytes goes through the copy state, the window read register and the
// output register to its first byte, then one byte per cycle while the output
// is taken, blocking the input until done; the window RAM's single read port
// gives one byte per cycle. Control bytes and first pair bytes yield nothing.
// Unwritten window bytes read as zero through a fill count, so a stream
// start costs no clearing time. cfg_wr_data sets the write pointer used
// at the next stream start. Reset loads 2015 and empties the window.
// When the receiver stalls, the output register holds and the copy pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_window_decompressor_core #(
    parameter int WINDOW_BYTES = lzdc_pkg::WINDOW_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [lzdc_pkg::CFG_W-1:0]  cfg_wr_data,    // window_start_position
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [lzdc_pkg::BYTE_W-1:0] s_axis_tdata,   // compressed_byte
    input  wire logic                        s_axis_tuser,   // first_of_stream
    input  wire logic                        s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [lzdc_pkg::BYTE_W-1:0]      m_axis_tdata,   // plain_byte
    output logic                             m_axis_tlast
);

    lzdc_pkg::lzdc_cmd_t  cmd;
    lzdc_pkg::lzdc_stat_t stat;

    lzdc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .byte_in       (s_axis_tdata),
        .first_in      (s_axis_tuser),
        .last_in       (s_axis_tlast),
        .stat          (stat),
        .cmd           (cmd)
    );

    lzdc_dpath #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .byte_in       (s_axis_tdata),
        .cmd           (cmd),
        .stat          (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A copy in progress never overlaps the acceptance of a new item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_issue || cmd.consume) |-> !s_axis_tready)
    else $error("Copy active while input is ready.");

    // A copied byte is only loaded when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.consume |-> (!m_axis_tvalid || m_axis_tready))
    else $error("Copy overwrote a pending output item.");

    // Every byte written to the window appears as an output item next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.lit_write || cmd.consume) |=> m_axis_tvalid)
    else $error("Window write without an output item.");

    // The last byte of a copy is output with tlast set.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.consume_last |=> (m_axis_tvalid && m_axis_tlast && s_axis_tready == 1'b0
                               || m_axis_tvalid && m_axis_tlast))
    else $error("Final copied byte without tlast.");

endmodule

`default_nettype wire
